@@ sv/ebs_pkg.sv @@
// shared types and constants of the eyelid blink sequencer
package ebs_pkg;

	// field widths
	localparam int POS_BITS      = 12;
	localparam int PROG_BITS     = 17;
	localparam int FRAC_BITS     = 16;
	localparam int INTERVAL_BITS = 18;
	localparam int TIME_BITS     = 32;
	localparam int DRAW_BITS     = 16;
	localparam int PHASE_BITS    = 3;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 17;

	// fixed constants
	localparam logic [PROG_BITS-1:0] ONE_Q16        = 17'h1_0000;
	localparam logic [DRAW_BITS-1:0] PUPIL_BUMP     = 16'd819;
	localparam int unsigned           FIRST_BLINK_DELAY_DEF = 1000;

	// reported phase codes
	localparam logic [PHASE_BITS-1:0] PHASE_CODE_WAIT    = 3'd0;
	localparam logic [PHASE_BITS-1:0] PHASE_CODE_CLOSING = 3'd2;
	localparam logic [PHASE_BITS-1:0] PHASE_CODE_CLOSED  = 3'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_BLINK_ENABLE  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_UPPER_LID_MIN = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_UPPER_LID_MAX = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LOWER_LID_MIN = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LOWER_LID_MAX = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLOSE_STEP    = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ROLL_ENABLE   = 3'd6;

	// persistent blink phases
	typedef enum logic [2:0] {
		PH_WAIT    = 3'b001,
		PH_CLOSING = 3'b010,
		PH_HOLD    = 3'b100
	} phase_t;

	typedef struct packed {
		logic                 blink_enable;
		logic [POS_BITS-1:0]  upper_lid_min;
		logic [POS_BITS-1:0]  upper_lid_max;
		logic [POS_BITS-1:0]  lower_lid_min;
		logic [POS_BITS-1:0]  lower_lid_max;
		logic [PROG_BITS-1:0] close_step;
		logic                 roll_enable;
	} cfg_t;

	typedef struct packed {
		logic [TIME_BITS-1:0]        now_ms;
		logic [DRAW_BITS-1:0]        drawn_closed_time;
		logic [DRAW_BITS-1:0]        drawn_gap;
		logic signed [DRAW_BITS-1:0] drawn_roll;
		logic [DRAW_BITS-1:0]        pupil_target;
	} item_t;

	typedef struct packed {
		logic [POS_BITS-1:0]         upper_target;
		logic [POS_BITS-1:0]         lower_target;
		logic                        target_written;
		logic [POS_BITS-1:0]         upper_current;
		logic [POS_BITS-1:0]         lower_current;
		logic                        current_written;
		logic signed [DRAW_BITS-1:0] roll_value;
		logic                        roll_written;
		logic [DRAW_BITS-1:0]        pupil_current;
		logic                        pupil_written;
		logic [PHASE_BITS-1:0]       phase_out;
	} res_t;

endpackage

@@ sv/ebs_interp.sv @@
// lid position interpolation between min and max by a Q1.16 progress
module ebs_interp
	import ebs_pkg::*;
(
	input  logic [POS_BITS-1:0]  lo,
	input  logic [POS_BITS-1:0]  hi,
	input  logic [PROG_BITS-1:0] prog,
	output logic [POS_BITS-1:0]  pos
);

	localparam int AW = POS_BITS + PROG_BITS + 2;

	logic signed [POS_BITS:0]  diff;
	logic signed [PROG_BITS:0] prog_s;
	logic signed [AW-1:0]      prod;
	logic signed [AW-1:0]      acc;

	// lo + (hi - lo) * p, rounded to nearest
	assign diff   = $signed({1'b0, hi}) - $signed({1'b0, lo});
	assign prog_s = $signed({1'b0, prog});
	assign prod   = diff * prog_s;
	assign acc    = prod + $signed(AW'({lo, 1'b1, {(FRAC_BITS-1){1'b0}}}));
	assign pos    = acc[FRAC_BITS +: POS_BITS];

endmodule

@@ sv/ebs_step.sv @@
// blink phase sequencing: state registers and the per-update result logic
module ebs_step
	import ebs_pkg::*;
#(
	parameter int unsigned FIRST_BLINK_DELAY = FIRST_BLINK_DELAY_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  cfg_t  cfg,
	input  item_t item,
	output res_t  res
);

	phase_t                   phase_q, phase_d;
	logic                     first_q, first_d;
	logic [TIME_BITS-1:0]     last_q, last_d;
	logic [INTERVAL_BITS-1:0] next_int_q, next_int_d;
	logic [DRAW_BITS-1:0]     hold_q, hold_d;
	logic [PROG_BITS-1:0]     progress_q, progress_d;
	logic [TIME_BITS-1:0]     closed_q, closed_d;

	logic [TIME_BITS-1:0]     wait_el, hold_el;
	logic                     go_start, finish, closing, in_hold, hold_pass;
	logic [PROG_BITS-1:0]     p_eff, prog_sat;
	logic [PROG_BITS:0]       prog_sum;
	logic [DRAW_BITS:0]       pupil_sum;
	logic [INTERVAL_BITS-1:0] interval_new;
	logic [POS_BITS-1:0]      up_pos, lo_pos;

	// phase decisions
	assign wait_el  = item.now_ms - last_q;
	assign hold_el  = item.now_ms - closed_q;
	assign go_start = (phase_q == PH_WAIT) && (wait_el >= TIME_BITS'(next_int_q));
	assign finish   = (phase_q == PH_CLOSING) && (progress_q >= ONE_Q16);
	assign closing  = go_start || ((phase_q == PH_CLOSING) && !finish);
	assign in_hold  = finish || (phase_q == PH_HOLD);
	assign hold_pass = finish ? (hold_q == '0) : (hold_el >= TIME_BITS'(hold_q));

	// progress advance with saturation at full close
	assign p_eff    = go_start ? '0 : progress_q;
	assign prog_sum = {1'b0, p_eff} + {1'b0, cfg.close_step};
	assign prog_sat = (prog_sum > (PROG_BITS+1)'(ONE_Q16)) ? ONE_Q16 : prog_sum[PROG_BITS-1:0];

	// pupil bump and next gap
	assign pupil_sum    = {1'b0, item.pupil_target} + {1'b0, PUPIL_BUMP};
	assign interval_new = {1'b0, hold_q, 1'b0} + INTERVAL_BITS'(hold_q)
	                    + INTERVAL_BITS'(item.drawn_gap);

	// lid interpolation
	ebs_interp u_interp_up (
		.lo   (cfg.upper_lid_min),
		.hi   (cfg.upper_lid_max),
		.prog (p_eff),
		.pos  (up_pos)
	);

	ebs_interp u_interp_lo (
		.lo   (cfg.lower_lid_min),
		.hi   (cfg.lower_lid_max),
		.prog (p_eff),
		.pos  (lo_pos)
	);

	// result and next state
	always_comb begin
		res        = '0;
		phase_d    = phase_q;
		first_d    = first_q;
		last_d     = last_q;
		next_int_d = next_int_q;
		hold_d     = hold_q;
		progress_d = progress_q;
		closed_d   = closed_q;
		res.phase_out = PHASE_CODE_WAIT;

		if (!cfg.blink_enable) begin
			// disabled: park lids at minimum once
			if ((phase_q != PH_WAIT) || first_q) begin
				res.upper_target   = cfg.upper_lid_min;
				res.lower_target   = cfg.lower_lid_min;
				res.target_written = 1'b1;
			end
			phase_d = PH_WAIT;
			first_d = 1'b0;
		end else begin
			// until the first blink ends, lids are forced to max unless a closing step overrides
			if (first_q) begin
				res.upper_target    = cfg.upper_lid_max;
				res.lower_target    = cfg.lower_lid_max;
				res.target_written  = 1'b1;
				res.upper_current   = cfg.upper_lid_max;
				res.lower_current   = cfg.lower_lid_max;
				res.current_written = 1'b1;
			end

			if (closing) begin
				// closing step
				res.upper_target    = up_pos;
				res.lower_target    = lo_pos;
				res.target_written  = 1'b1;
				res.upper_current   = up_pos;
				res.lower_current   = lo_pos;
				res.current_written = 1'b1;
				if (go_start) begin
					hold_d = item.drawn_closed_time;
				end
				progress_d    = prog_sat;
				phase_d       = PH_CLOSING;
				res.phase_out = PHASE_CODE_CLOSING;
			end else if (in_hold) begin
				// entering closed: lids at max, pupil bump
				if (finish) begin
					res.upper_target    = cfg.upper_lid_max;
					res.lower_target    = cfg.lower_lid_max;
					res.target_written  = 1'b1;
					res.upper_current   = cfg.upper_lid_max;
					res.lower_current   = cfg.lower_lid_max;
					res.current_written = 1'b1;
					res.pupil_current   = pupil_sum[DRAW_BITS] ? '1 : pupil_sum[DRAW_BITS-1:0];
					res.pupil_written   = 1'b1;
					closed_d            = item.now_ms;
				end
				if (hold_pass) begin
					// open and schedule the next blink
					res.upper_target   = cfg.upper_lid_min;
					res.lower_target   = cfg.lower_lid_min;
					res.target_written = 1'b1;
					if (cfg.roll_enable) begin
						res.roll_value   = item.drawn_roll;
						res.roll_written = 1'b1;
					end
					progress_d = ONE_Q16;
					last_d     = item.now_ms;
					next_int_d = interval_new;
					phase_d    = PH_WAIT;
					first_d    = 1'b0;
				end else begin
					phase_d       = PH_HOLD;
					res.phase_out = PHASE_CODE_CLOSED;
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WAIT;
			first_q    <= 1'b1;
			last_q     <= '0;
			next_int_q <= INTERVAL_BITS'(FIRST_BLINK_DELAY);
			hold_q     <= '0;
			progress_q <= '0;
			closed_q   <= '0;
		end else if (adv) begin
			phase_q    <= phase_d;
			first_q    <= first_d;
			last_q     <= last_d;
			next_int_q <= next_int_d;
			hold_q     <= hold_d;
			progress_q <= progress_d;
			closed_q   <= closed_d;
		end
	end

endmodule

@@ sv/eyelid_blink_sequencer_top.sv @@
// top level of the eyelid blink sequencer: config registers, request and result stages
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  in       | in_valid / in_stall        | now_ms, drawn_*, pupil_target
//  out      | out_valid / out_stall      | lid targets/currents, roll, pupil, phase
//  config   | cfg_we, cfg_index          | cfg_data (17 bits, low bits used)
//
// one request per cycle sustained while out_stall stays low; a taken request shows its result
// valid after passing through the request register and then the result register.
// reset clears both stages, the blink state and the config registers to their defaults.
// a stalled result holds; the request stage keeps accepting while the result register
// can drain, so in_stall rises only when both stages are full and out_stall is high.
module eyelid_blink_sequencer_top
	import ebs_pkg::*;
#(
	parameter int unsigned FIRST_BLINK_DELAY = FIRST_BLINK_DELAY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [TIME_BITS-1:0]        now_ms,
	input  logic [DRAW_BITS-1:0]        drawn_closed_time,
	input  logic [DRAW_BITS-1:0]        drawn_gap,
	input  logic signed [DRAW_BITS-1:0] drawn_roll,
	input  logic [DRAW_BITS-1:0]        pupil_target,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [POS_BITS-1:0]         upper_target,
	output logic [POS_BITS-1:0]         lower_target,
	output logic                        target_written,
	output logic [POS_BITS-1:0]         upper_current,
	output logic [POS_BITS-1:0]         lower_current,
	output logic                        current_written,
	output logic signed [DRAW_BITS-1:0] roll_value,
	output logic                        roll_written,
	output logic [DRAW_BITS-1:0]        pupil_current,
	output logic                        pupil_written,
	output logic [PHASE_BITS-1:0]       phase_out
);

	cfg_t  cfg_q;
	item_t item_s1;
	logic  valid_s1;
	res_t  res_d, res_s2;
	logic  valid_s2;
	logic  adv, accept;

	// stage handshake
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;
	assign accept   = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blink_enable  <= 1'b1;
			cfg_q.upper_lid_min <= '0;
			cfg_q.upper_lid_max <= '1;
			cfg_q.lower_lid_min <= '0;
			cfg_q.lower_lid_max <= '1;
			cfg_q.close_step    <= PROG_BITS'(6554);
			cfg_q.roll_enable   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BLINK_ENABLE:  cfg_q.blink_enable  <= cfg_data[0];
				CFG_UPPER_LID_MIN: cfg_q.upper_lid_min <= cfg_data[POS_BITS-1:0];
				CFG_UPPER_LID_MAX: cfg_q.upper_lid_max <= cfg_data[POS_BITS-1:0];
				CFG_LOWER_LID_MIN: cfg_q.lower_lid_min <= cfg_data[POS_BITS-1:0];
				CFG_LOWER_LID_MAX: cfg_q.lower_lid_max <= cfg_data[POS_BITS-1:0];
				CFG_CLOSE_STEP:    cfg_q.close_step    <= cfg_data[PROG_BITS-1:0];
				CFG_ROLL_ENABLE:   cfg_q.roll_enable   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// request stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.now_ms            <= now_ms;
			item_s1.drawn_closed_time <= drawn_closed_time;
			item_s1.drawn_gap         <= drawn_gap;
			item_s1.drawn_roll        <= drawn_roll;
			item_s1.pupil_target      <= pupil_target;
		end
	end

	// phase logic
	ebs_step #(
		.FIRST_BLINK_DELAY (FIRST_BLINK_DELAY)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cfg    (cfg_q),
		.item   (item_s1),
		.res    (res_d)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid       = valid_s2;
	assign upper_target    = res_s2.upper_target;
	assign lower_target    = res_s2.lower_target;
	assign target_written  = res_s2.target_written;
	assign upper_current   = res_s2.upper_current;
	assign lower_current   = res_s2.lower_current;
	assign current_written = res_s2.current_written;
	assign roll_value      = res_s2.roll_value;
	assign roll_written    = res_s2.roll_written;
	assign pupil_current   = res_s2.pupil_current;
	assign pupil_written   = res_s2.pupil_written;
	assign phase_out       = res_s2.phase_out;

`ifndef ASSERT_OFF
	// a pending request moves into a drained result register
	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_stall) |=> valid_s2)
		else $error("pending request not moved to result stage");

	// only the persistent phase codes are reported
	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (phase_out == PHASE_CODE_WAIT || phase_out == PHASE_CODE_CLOSING
			|| phase_out == PHASE_CODE_CLOSED))
		else $error("transient phase code reported");

	// a current override always comes with a target write
	a_cur_tgt: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && current_written) |-> target_written)
		else $error("current written without target");

	// pupil is written only on entry to closed
	a_pupil: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pupil_written) |-> (phase_out != PHASE_CODE_CLOSING && current_written))
		else $error("pupil written outside close completion");
`endif

endmodule
